/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use checks on the rising edge of
// i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every checked edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rcst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcst_pkg;

    // Table geometry.
    localparam int SLOTS       = 64;
    localparam int NUMBER_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Port field widths.
    localparam int CMD_W     = 2;
    localparam int OBJ_W     = 16;
    localparam int IDX_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_MARK  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2,
        STAT_SAT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUT_RD,
        S_PUT_CHK,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     slot;
        logic                 hit;
        logic                 load;
        logic                 wb;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/refcounted_slot_table.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// request  | in        | i_in_valid / o_in_stall    | i_command, i_object_number,
//          |           |                            | i_slot_index
// result   | out       | o_out_valid / i_out_stall  | o_status, o_result_slot, o_hit,
//          |           |                            | o_load_needed, o_writeback_needed,
//          |           |                            | o_count_after
//
// A get holds off further requests from acceptance while it scans; the single
// read port of the slot memories scans one slot per cycle and stops early on a
// hit. A put reads, checks and updates its slot, skipping the update when the
// slot is unused, and clear-all and mark-all-in-use go straight to the result.
// Reset (synchronous, active low) empties the table at once through per-slot
// valid bits, so no clearing pass follows it.
// A finished result sits in the output register while the next request is taken;
// a result only waits for the output register when the previous one is stalled.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module refcounted_slot_table
    import rcst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [OBJ_W-1:0]      i_object_number,
    input  wire logic [IDX_W-1:0]      i_slot_index,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STAT_W-1:0]          o_status,
    output logic [IDX_W-1:0]           o_result_slot,
    output logic                       o_hit,
    output logic                       o_load_needed,
    output logic                       o_writeback_needed,
    output logic [CNT_OUT_W-1:0]       o_count_after
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [ADDR_W-1:0]     LAST_IDX = ADDR_W'(SLOTS - 1);
    localparam logic [ADDR_W:0]       SCAN_END = (ADDR_W + 1)'(SLOTS);

    // Slot memories. An entry whose valid bit is clear reads as its reset value
    // (number zero) or, for counts, as the value of the last clear or mark-all.
    logic [NUMBER_BITS-1:0] r_num_mem [SLOTS];
    logic [COUNT_BITS-1:0]  r_cnt_mem [SLOTS];
    logic [SLOTS-1:0]       r_n_valid;
    logic [SLOTS-1:0]       r_c_valid;
    logic                   r_cnt_base;

    // Registered read port.
    logic [NUMBER_BITS-1:0] r_num_rd;
    logic [COUNT_BITS-1:0]  r_cnt_rd;
    logic                   r_nv_q;
    logic                   r_cv_q;

    t_state                 r_state;
    t_state                 n_state;

    // Scan and request bookkeeping.
    logic [ADDR_W:0]        r_addr;
    logic                   r_live;
    logic [ADDR_W-1:0]      r_live_idx;
    logic                   r_have_free;
    logic [ADDR_W-1:0]      r_free;
    logic [NUMBER_BITS-1:0] r_num;
    logic [ADDR_W-1:0]      r_tgt;
    logic [COUNT_BITS-1:0]  r_new_cnt;
    logic                   r_wr_cnt;
    t_result                r_res;

    // Output register.
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_accept;
    logic                   out_free;
    t_cmd                   cmd;
    logic                   put_in_range;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0]  eff_cnt;
    logic [NUMBER_BITS-1:0] eff_num;
    logic                   issue;
    logic                   scan_hit;
    logic                   scan_free;
    logic                   scan_last;
    logic                   free_any;
    logic [ADDR_W-1:0]      free_sel;
    logic                   wr_cnt_en;
    logic                   wr_num_en;
    logic                   clr_all;

    assign cmd          = t_cmd'(i_command);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign put_in_range = int'(i_slot_index) < SLOTS;
    assign clr_all      = in_accept && (cmd == CMD_CLEAR || cmd == CMD_MARK);

    // The shared compare unit looks at one slot per cycle: the slot read in the
    // previous cycle, with its valid bits applied.
    assign eff_cnt   = r_cv_q ? r_cnt_rd : (r_cnt_base ? CNT_ONE : '0);
    assign eff_num   = r_nv_q ? r_num_rd : '0;
    assign issue     = r_addr < SCAN_END;
    assign scan_hit  = r_live && (eff_cnt != '0) && (eff_num == r_num);
    assign scan_free = r_live && (eff_cnt == '0);
    assign scan_last = r_live && (r_live_idx == LAST_IDX);
    assign free_any  = r_have_free || scan_free;
    assign free_sel  = r_have_free ? r_free : r_live_idx;
    assign rd_addr   = (r_state == S_SCAN) ? r_addr[ADDR_W-1:0] : r_tgt;

    assign wr_cnt_en = (r_state == S_UPDATE) && r_wr_cnt;
    assign wr_num_en = (r_state == S_UPDATE) && r_res.load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_accept) begin
                    unique case (cmd)
                        CMD_GET:   n_state = S_SCAN;
                        CMD_PUT:   n_state = put_in_range ? S_PUT_RD : S_EMIT;
                        CMD_CLEAR: n_state = S_EMIT;
                        CMD_MARK:  n_state = S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_UPDATE;
                end else if (scan_last) begin
                    n_state = free_any ? S_UPDATE : S_EMIT;
                end
            end
            S_PUT_RD: begin
                n_state = S_PUT_CHK;
            end
            S_PUT_CHK: begin
                n_state = (eff_cnt == '0) ? S_EMIT : S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_cnt_en) begin
            r_cnt_mem[r_tgt] <= r_new_cnt;
        end
        if (wr_num_en) begin
            r_num_mem[r_tgt] <= r_num;
        end
        r_num_rd <= r_num_mem[rd_addr];
        r_cnt_rd <= r_cnt_mem[rd_addr];
        r_nv_q   <= r_n_valid[rd_addr];
        r_cv_q   <= r_c_valid[rd_addr];
    end

    // Valid bits. Clear-all and mark-all drop every count at once and let the
    // base value stand in for it; the stored numbers are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid  <= '0;
            r_c_valid  <= '0;
            r_cnt_base <= 1'b0;
        end else begin
            if (clr_all) begin
                r_c_valid  <= '0;
                r_cnt_base <= (cmd == CMD_MARK);
            end else if (wr_cnt_en) begin
                r_c_valid[r_tgt] <= 1'b1;
            end
            if (wr_num_en) begin
                r_n_valid[r_tgt] <= 1'b1;
            end
        end
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_live      <= 1'b0;
            r_have_free <= 1'b0;
            r_wr_cnt    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr      <= '0;
                    r_live      <= 1'b0;
                    r_have_free <= 1'b0;
                end
                S_SCAN: begin
                    r_live <= issue;
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (scan_free) begin
                        r_have_free <= 1'b1;
                    end
                    r_wr_cnt <= scan_hit ? (eff_cnt != CNT_MAX) : free_any;
                end
                S_PUT_CHK: begin
                    r_wr_cnt <= (eff_cnt != '0);
                end
                S_PUT_RD, S_UPDATE, S_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Request data, scan results and the staged result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_num        <= NUMBER_BITS'(i_object_number);
                    r_tgt        <= ADDR_W'(i_slot_index);
                    r_res.status <= (cmd == CMD_PUT) ? STAT_UNUSED : STAT_OK;
                    r_res.slot   <= (cmd == CMD_PUT) ? i_slot_index : '0;
                    r_res.hit    <= 1'b0;
                    r_res.load   <= 1'b0;
                    r_res.wb     <= 1'b0;
                    r_res.count  <= (cmd == CMD_MARK) ? CNT_OUT_W'(1) : '0;
                end
            end
            S_SCAN: begin
                r_live_idx <= r_addr[ADDR_W-1:0];
                if (scan_free && !r_have_free) begin
                    r_free <= r_live_idx;
                end
                if (scan_hit) begin
                    r_tgt     <= r_live_idx;
                    r_res.hit <= 1'b1;
                    r_res.slot <= IDX_W'(r_live_idx);
                    if (eff_cnt == CNT_MAX) begin
                        r_new_cnt    <= eff_cnt;
                        r_res.status <= STAT_SAT;
                        r_res.count  <= CNT_OUT_W'(eff_cnt);
                    end else begin
                        r_new_cnt    <= eff_cnt + 1'b1;
                        r_res.status <= STAT_OK;
                        r_res.count  <= CNT_OUT_W'(eff_cnt + 1'b1);
                    end
                end else if (scan_last) begin
                    if (free_any) begin
                        r_tgt        <= free_sel;
                        r_new_cnt    <= CNT_ONE;
                        r_res.status <= STAT_OK;
                        r_res.slot   <= IDX_W'(free_sel);
                        r_res.load   <= 1'b1;
                        r_res.count  <= CNT_OUT_W'(1);
                    end else begin
                        r_res.status <= STAT_FULL;
                    end
                end
            end
            S_PUT_CHK: begin
                r_res.slot <= IDX_W'(r_tgt);
                if (eff_cnt == '0) begin
                    r_res.status <= STAT_UNUSED;
                end else begin
                    r_new_cnt    <= eff_cnt - 1'b1;
                    r_res.status <= STAT_OK;
                    r_res.wb     <= (eff_cnt == CNT_ONE);
                    r_res.count  <= CNT_OUT_W'(eff_cnt - 1'b1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            S_PUT_RD, S_UPDATE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_result_slot      = r_out.slot;
    assign o_hit              = r_out.hit;
    assign o_load_needed      = r_out.load;
    assign o_writeback_needed = r_out.wb;
    assign o_count_after      = r_out.count;

    // A claimed slot always gets its number written along with its count.
    `ASSERT_NEXT(a_claim_writes, (r_state == S_UPDATE) && r_res.load,
        $past(wr_cnt_en) && $past(wr_num_en), "claim did not write number and count")

    // A hit never leaves a slot with a zero count.
    `ASSERT_NEXT(a_hit_nonzero, (r_state == S_UPDATE) && r_res.hit,
        $past(r_new_cnt) != '0, "hit produced a zero count")

    // Leaving the result state always loads the output register.
    `ASSERT_NEXT(a_emit_loads, (r_state == S_EMIT) && out_free,
        o_out_valid && (r_state == S_IDLE), "result not delivered to output")

    // Memory writes happen only while no request can be taken.
    `ASSERT_ALWAYS(a_write_busy, !(wr_cnt_en || wr_num_en) || o_in_stall,
        "slot memory written while idle")

endmodule

`default_nettype wire
